@@ design/urbrf_pkg.sv @@
package urbrf_pkg;

    // Receive FIFO geometry and interrupt trigger level.
    localparam int FIFO_DEPTH = 16;
    localparam int RX_TRIGGER = 1;
    localparam int HEAD_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Command queue between the decoder and the execution stage.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Action codes on the input beat.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_RECV  = 2'd2;

    // Register offsets within the window.
    localparam logic [11:0] OFF_DR    = 12'h000;
    localparam logic [11:0] OFF_FR    = 12'h018;
    localparam logic [11:0] OFF_ILPR  = 12'h020;
    localparam logic [11:0] OFF_IBRD  = 12'h024;
    localparam logic [11:0] OFF_FBRD  = 12'h028;
    localparam logic [11:0] OFF_LCR   = 12'h02C;
    localparam logic [11:0] OFF_CR    = 12'h030;
    localparam logic [11:0] OFF_IFLS  = 12'h034;
    localparam logic [11:0] OFF_IMSC  = 12'h038;
    localparam logic [11:0] OFF_RIS   = 12'h03C;
    localparam logic [11:0] OFF_MIS   = 12'h040;
    localparam logic [11:0] OFF_ICR   = 12'h044;
    localparam logic [11:0] OFF_DMACR = 12'h048;
    localparam logic [11:0] OFF_ID0   = 12'hFE0;

    // Reset values and bit masks.
    localparam logic [31:0] FLAG_RESET = 32'h0000_0090;
    localparam logic [31:0] CR_RESET   = 32'h0000_0300;
    localparam logic [31:0] IFLS_RESET = 32'h0000_0012;
    localparam logic [31:0] FLAG_RXFE  = 32'h0000_0010;
    localparam logic [31:0] FLAG_RXFF  = 32'h0000_0040;
    localparam logic [31:0] LCR_FEN    = 32'h0000_0010;
    localparam logic [31:0] RIS_RX     = 32'h0000_0010;
    localparam logic [31:0] RIS_TX     = 32'h0000_0020;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_RECV,
        KIND_NONE
    } cmd_kind_t;

    typedef enum logic [3:0] {
        REG_DR,
        REG_FR,
        REG_ILPR,
        REG_IBRD,
        REG_FBRD,
        REG_LCR,
        REG_CR,
        REG_IFLS,
        REG_IMSC,
        REG_RIS,
        REG_MIS,
        REG_ICR,
        REG_DMACR,
        REG_ID,
        REG_NONE
    } reg_sel_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] reg_offset;
        logic [31:0] write_word;
        logic [7:0]  rx_char;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] read_word;
        logic        tx_valid;
        logic [7:0]  tx_char;
        logic        irq_line;
        logic        rx_dropped;
    } out_beat_t;

    typedef struct packed {
        cmd_kind_t   kind;
        reg_sel_t    sel;
        logic [2:0]  id_index;
        logic [31:0] write_word;
        logic [7:0]  rx_char;
    } cmd_t;

    function automatic logic [31:0] id_value(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h11;
            3'd1:    v = 32'h10;
            3'd2:    v = 32'h14;
            3'd3:    v = 32'h00;
            3'd4:    v = 32'h0D;
            3'd5:    v = 32'hF0;
            3'd6:    v = 32'h05;
            3'd7:    v = 32'hB1;
            default: v = 32'h00;
        endcase
        return v;
    endfunction

endpackage

@@ design/urbrf_front.sv @@
module urbrf_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  urbrf_pkg::in_beat_t s_data,
    input  logic               q_full,
    output logic               q_push,
    output urbrf_pkg::cmd_t    q_cmd
);

    // Decode the offset once so the execution stage sees a register code.
    function automatic urbrf_pkg::reg_sel_t decode(input logic [11:0] off);
        urbrf_pkg::reg_sel_t r;
        case (off)
            urbrf_pkg::OFF_DR:    r = urbrf_pkg::REG_DR;
            urbrf_pkg::OFF_FR:    r = urbrf_pkg::REG_FR;
            urbrf_pkg::OFF_ILPR:  r = urbrf_pkg::REG_ILPR;
            urbrf_pkg::OFF_IBRD:  r = urbrf_pkg::REG_IBRD;
            urbrf_pkg::OFF_FBRD:  r = urbrf_pkg::REG_FBRD;
            urbrf_pkg::OFF_LCR:   r = urbrf_pkg::REG_LCR;
            urbrf_pkg::OFF_CR:    r = urbrf_pkg::REG_CR;
            urbrf_pkg::OFF_IFLS:  r = urbrf_pkg::REG_IFLS;
            urbrf_pkg::OFF_IMSC:  r = urbrf_pkg::REG_IMSC;
            urbrf_pkg::OFF_RIS:   r = urbrf_pkg::REG_RIS;
            urbrf_pkg::OFF_MIS:   r = urbrf_pkg::REG_MIS;
            urbrf_pkg::OFF_ICR:   r = urbrf_pkg::REG_ICR;
            urbrf_pkg::OFF_DMACR: r = urbrf_pkg::REG_DMACR;
            default: begin
                if (off >= urbrf_pkg::OFF_ID0 && off[1:0] == 2'b00) begin
                    r = urbrf_pkg::REG_ID;
                end else begin
                    r = urbrf_pkg::REG_NONE;
                end
            end
        endcase
        return r;
    endfunction

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        case (s_data.action)
            urbrf_pkg::ACT_READ:  q_cmd.kind = urbrf_pkg::KIND_READ;
            urbrf_pkg::ACT_WRITE: q_cmd.kind = urbrf_pkg::KIND_WRITE;
            urbrf_pkg::ACT_RECV:  q_cmd.kind = urbrf_pkg::KIND_RECV;
            default:              q_cmd.kind = urbrf_pkg::KIND_NONE;
        endcase
        q_cmd.sel        = decode(s_data.reg_offset);
        q_cmd.id_index   = s_data.reg_offset[4:2];
        q_cmd.write_word = s_data.write_word;
        q_cmd.rx_char    = s_data.rx_char;
    end

endmodule

@@ design/urbrf_queue.sv @@
module urbrf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  urbrf_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output urbrf_pkg::cmd_t head_cmd
);

    urbrf_pkg::cmd_t                    slot_mem [urbrf_pkg::QUEUE_DEPTH];
    logic [urbrf_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [urbrf_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [urbrf_pkg::QCNT_W-1:0]       count_reg;
    logic                               do_pop;

    assign full       = (count_reg == urbrf_pkg::QCNT_W'(urbrf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    function automatic logic [urbrf_pkg::QPTR_W-1:0] bump(
        input logic [urbrf_pkg::QPTR_W-1:0] p
    );
        logic [urbrf_pkg::QPTR_W-1:0] n;
        if (p == urbrf_pkg::QPTR_W'(urbrf_pkg::QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= urbrf_pkg::QCNT_W'(urbrf_pkg::QUEUE_DEPTH))
        else $error("command queue count beyond its depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("command pushed into a full queue");

endmodule

@@ design/urbrf_back.sv @@
module urbrf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  urbrf_pkg::cmd_t      cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output urbrf_pkg::out_beat_t m_data
);

    localparam int D  = urbrf_pkg::FIFO_DEPTH;
    localparam int HW = urbrf_pkg::HEAD_W;
    localparam int CW = urbrf_pkg::CNT_W;

    logic [7:0]    rx_store_reg [D];
    logic [HW-1:0] rx_head_reg, rx_head_next;
    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [31:0]   flag_reg, flag_next;
    logic [31:0]   ctrl_reg, ctrl_next;
    logic [31:0]   ifls_reg, ifls_next;
    logic [31:0]   lcr_reg, lcr_next;
    logic [31:0]   imsc_reg, imsc_next;
    logic [31:0]   ris_reg, ris_next;
    logic [31:0]   ibrd_reg, ibrd_next;
    logic [31:0]   fbrd_reg, fbrd_next;
    logic [31:0]   ilpr_reg, ilpr_next;
    logic [31:0]   dmacr_reg, dmacr_next;

    logic                 m_valid_reg;
    urbrf_pkg::out_beat_t m_data_reg, m_data_next;

    logic          fire;
    logic          store_we;
    logic [HW:0]   slot_sum;
    logic [HW-1:0] slot;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Tail position of the receive FIFO.
    always_comb begin
        slot_sum = {1'b0, rx_head_reg} + {1'b0, rx_count_reg[HW-1:0]};
        if (slot_sum >= (HW+1)'(D)) begin
            slot_sum = slot_sum - (HW+1)'(D);
        end
        slot = slot_sum[HW-1:0];
    end

    always_comb begin
        rx_head_next  = rx_head_reg;
        rx_count_next = rx_count_reg;
        flag_next     = flag_reg;
        ctrl_next     = ctrl_reg;
        ifls_next     = ifls_reg;
        lcr_next      = lcr_reg;
        imsc_next     = imsc_reg;
        ris_next      = ris_reg;
        ibrd_next     = ibrd_reg;
        fbrd_next     = fbrd_reg;
        ilpr_next     = ilpr_reg;
        dmacr_next    = dmacr_reg;
        store_we      = 1'b0;
        m_data_next   = '0;

        case (cmd.kind)
            urbrf_pkg::KIND_READ: begin
                case (cmd.sel)
                    urbrf_pkg::REG_DR: begin
                        flag_next = flag_next & ~urbrf_pkg::FLAG_RXFF;
                        m_data_next.read_word = {24'd0, rx_store_reg[rx_head_reg]};
                        if (rx_count_reg != '0) begin
                            rx_count_next = rx_count_reg - 1'b1;
                            if (rx_head_reg == HW'(D - 1)) begin
                                rx_head_next = '0;
                            end else begin
                                rx_head_next = rx_head_reg + 1'b1;
                            end
                        end
                        if (rx_count_next == '0) begin
                            flag_next = flag_next | urbrf_pkg::FLAG_RXFE;
                        end
                        if (rx_count_next == CW'(urbrf_pkg::RX_TRIGGER - 1)) begin
                            ris_next = ris_next & ~urbrf_pkg::RIS_RX;
                        end
                    end
                    urbrf_pkg::REG_FR:    m_data_next.read_word = flag_reg;
                    urbrf_pkg::REG_ILPR:  m_data_next.read_word = ilpr_reg;
                    urbrf_pkg::REG_IBRD:  m_data_next.read_word = ibrd_reg;
                    urbrf_pkg::REG_FBRD:  m_data_next.read_word = fbrd_reg;
                    urbrf_pkg::REG_LCR:   m_data_next.read_word = lcr_reg;
                    urbrf_pkg::REG_CR:    m_data_next.read_word = ctrl_reg;
                    urbrf_pkg::REG_IFLS:  m_data_next.read_word = ifls_reg;
                    urbrf_pkg::REG_IMSC:  m_data_next.read_word = imsc_reg;
                    urbrf_pkg::REG_RIS:   m_data_next.read_word = ris_reg;
                    urbrf_pkg::REG_MIS:   m_data_next.read_word = ris_reg & imsc_reg;
                    urbrf_pkg::REG_DMACR: m_data_next.read_word = dmacr_reg;
                    urbrf_pkg::REG_ID:    m_data_next.read_word = urbrf_pkg::id_value(cmd.id_index);
                    default:              m_data_next.read_word = '0;
                endcase
            end
            urbrf_pkg::KIND_WRITE: begin
                case (cmd.sel)
                    urbrf_pkg::REG_DR: begin
                        ris_next             = ris_next | urbrf_pkg::RIS_TX;
                        m_data_next.tx_valid = 1'b1;
                        m_data_next.tx_char  = cmd.write_word[7:0];
                    end
                    urbrf_pkg::REG_FR:    flag_next  = cmd.write_word;
                    urbrf_pkg::REG_ILPR:  ilpr_next  = cmd.write_word;
                    urbrf_pkg::REG_IBRD:  ibrd_next  = cmd.write_word;
                    urbrf_pkg::REG_FBRD:  fbrd_next  = cmd.write_word;
                    urbrf_pkg::REG_LCR:   lcr_next   = cmd.write_word;
                    urbrf_pkg::REG_CR:    ctrl_next  = cmd.write_word;
                    urbrf_pkg::REG_IFLS:  ifls_next  = cmd.write_word;
                    urbrf_pkg::REG_IMSC:  imsc_next  = cmd.write_word;
                    urbrf_pkg::REG_RIS:   ris_next   = cmd.write_word;
                    urbrf_pkg::REG_ICR:   ris_next   = ris_reg & ~cmd.write_word;
                    urbrf_pkg::REG_DMACR: dmacr_next = cmd.write_word;
                    default: ;
                endcase
            end
            urbrf_pkg::KIND_RECV: begin
                if (rx_count_reg >= CW'(D)) begin
                    m_data_next.rx_dropped = 1'b1;
                end else begin
                    store_we      = 1'b1;
                    rx_count_next = rx_count_reg + 1'b1;
                    flag_next     = flag_next & ~urbrf_pkg::FLAG_RXFE;
                    if ((lcr_reg & urbrf_pkg::LCR_FEN) == '0 || rx_count_next == CW'(D)) begin
                        flag_next = flag_next | urbrf_pkg::FLAG_RXFF;
                    end
                    if (rx_count_next == CW'(urbrf_pkg::RX_TRIGGER)) begin
                        ris_next = ris_next | urbrf_pkg::RIS_RX;
                    end
                end
            end
            default: ;
        endcase

        m_data_next.irq_line = ((ris_next & imsc_next) != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < D; i++) begin
                rx_store_reg[i] <= '0;
            end
        end else if (fire && store_we) begin
            rx_store_reg[slot] <= cmd.rx_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            rx_head_reg  <= '0;
            rx_count_reg <= '0;
            flag_reg     <= urbrf_pkg::FLAG_RESET;
            ctrl_reg     <= urbrf_pkg::CR_RESET;
            ifls_reg     <= urbrf_pkg::IFLS_RESET;
            lcr_reg      <= '0;
            imsc_reg     <= '0;
            ris_reg      <= '0;
            ibrd_reg     <= '0;
            fbrd_reg     <= '0;
            ilpr_reg     <= '0;
            dmacr_reg    <= '0;
        end else begin
            if (cmd_ready) begin
                m_valid_reg <= cmd_valid;
            end
            if (fire) begin
                rx_head_reg  <= rx_head_next;
                rx_count_reg <= rx_count_next;
                flag_reg     <= flag_next;
                ctrl_reg     <= ctrl_next;
                ifls_reg     <= ifls_next;
                lcr_reg      <= lcr_next;
                imsc_reg     <= imsc_next;
                ris_reg      <= ris_next;
                ibrd_reg     <= ibrd_next;
                fbrd_reg     <= fbrd_next;
                ilpr_reg     <= ilpr_next;
                dmacr_reg    <= dmacr_next;
            end
        end
    end

    a_rx_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= CW'(D))
        else $error("receive FIFO count beyond its depth");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cmd.kind == urbrf_pkg::KIND_RECV && rx_count_reg == CW'(D))
        |=> (m_data_reg.rx_dropped && $stable(rx_count_reg)))
        else $error("character on a full FIFO was not dropped");

    a_irq_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(fire) |-> (m_data_reg.irq_line == ((ris_reg & imsc_reg) != '0)))
        else $error("interrupt level disagrees with status and mask");

endmodule

@@ design/uart_register_block_rx_fifo.sv @@
// Channel   Direction  Ports                        Beat type
// s_        in         s_valid s_ready s_data       urbrf_pkg::in_beat_t
// m_        out        m_valid m_ready m_data       urbrf_pkg::out_beat_t
//
// One beat is accepted per cycle while the two-entry command queue has room.
// A beat is decoded and queued at its accepting edge; the execution stage
// registers its result as it takes the beat, holding it on m_ until taken.
// Reset (aresetn low, synchronous) empties the queue and the output register
// and restores every register and the receive FIFO to its reset value.
// A stall on m_ fills the queue, after which s_ready falls until a beat drains.
module uart_register_block_rx_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  urbrf_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output urbrf_pkg::out_beat_t m_data
);

    // Front end to queue.
    logic            q_full;
    logic            q_push;
    urbrf_pkg::cmd_t q_cmd;

    // Queue to execution stage.
    logic            head_valid;
    logic            head_pop;
    urbrf_pkg::cmd_t head_cmd;

    // The front end turns each beat into an action kind and a register code;
    // the offset comparison is thereby kept off the execution stage's path.
    urbrf_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // The queue lets the input keep flowing for a beat or two while the
    // result side is stalled, and lets the result side drain on its own.
    urbrf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The execution stage holds the register file and the receive FIFO, applies
    // one command per cycle unless m_ stalls; each recomputes the irq level.
    urbrf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (head_valid),
        .cmd_ready (head_pop),
        .cmd       (head_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
